>>> rtl/core/lrd_pkg.sv
// Shared types, codes and the bytewise CRC-32C update for the log record deframer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrd_pkg;

    localparam int unsigned HDR_BYTES       = 8;
    localparam logic [31:0] DEFAULT_MAX_LEN = 32'd67108864;   // 64 MiB
    localparam logic [31:0] CRC_POLY        = 32'h82F63B78;   // reflected CRC-32C
    localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
    localparam logic [31:0] MASK_DELTA      = 32'hA282EAD8;

    // parser phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ENDED   = 2'd2
    } t_phase;

    // record status codes
    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_GOOD      = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_BAD_CRC   = 3'd3;
    localparam logic [2:0] ST_CLEAN_END = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;

    // config register indexes
    localparam logic REG_MAX_LEN = 1'b0;

    // one byte through the reflected CRC-32C register (no inversion)
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // masked CRC as stored in the header: inverted, rotated right 15, plus delta
    function automatic logic [31:0] crc_mask(input logic [31:0] crc);
        logic [31:0] c;
        c = ~crc;
        return {c[14:0], c[31:15]} + MASK_DELTA;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/log_record_deframer.sv
// Log record deframer top level: header parse, CRC-32C check, payload pass-through.
// Depends on lrd_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Result words are registered: a result word appears on the master side in the cycle after its input word is taken.
// Throughput: one input word per cycle; the only stall is a full output register whose
// word is not being taken (s_axis_tready = !r_out_valid | m_axis_tready).
// Reset (i_rst_n low, synchronous): parser back to header phase with count zero, CRC to
// all ones, output register empty, max_record_length back to 64 MiB.
module log_record_deframer (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    // input stream
    input  wire  logic        s_axis_tvalid,
    output       logic        s_axis_tready,
    input  wire  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire  logic        s_axis_tuser,   // [0] end_of_log
    // result stream
    output       logic        m_axis_tvalid,
    input  wire  logic        m_axis_tready,
    output       logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
    output       logic [3:0]  m_axis_tuser,   // [0] byte_valid, [3:1] record_status
    output       logic        m_axis_tlast,   // record_last
    // configuration
    input  wire  logic        psel,
    input  wire  logic        penable,
    input  wire  logic        pwrite,
    input  wire  logic [2:0]  paddr,
    input  wire  logic [31:0] pwdata,
    output       logic [31:0] prdata,
    output       logic        pready
);
    import lrd_pkg::*;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [31:0] r_max_len;
    logic        cfg_wr;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= DEFAULT_MAX_LEN;
        end else if (cfg_wr && reg_idx == REG_MAX_LEN) begin
            r_max_len <= pwdata;
        end
    end

    assign prdata = (reg_idx == REG_MAX_LEN) ? r_max_len : 32'd0;

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    t_phase      r_phase,    n_phase;
    logic [2:0]  r_hdr_cnt,  n_hdr_cnt;
    logic [31:0] r_stored,   n_stored;   // masked CRC from header
    logic [31:0] r_len,      n_len;      // length from header
    logic [31:0] r_left,     n_left;     // payload bytes still due
    logic [31:0] r_crc,      n_crc;      // running CRC, not inverted

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_bvalid;
    logic [2:0]  r_out_status;
    logic        r_out_last;

    logic        in_acc;
    logic        eol;
    logic [7:0]  din;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign din           = s_axis_tdata;
    assign eol           = s_axis_tuser;

    // ---------------------------------------------------------------
    // Shared datapath terms
    // ---------------------------------------------------------------
    logic [31:0] crc_upd;     // CRC after this byte
    logic [31:0] len_full;    // length once the last header byte lands
    logic        len_over;
    logic        len_zero;
    logic        crc_ok;
    logic        hdr_last;
    logic        pay_last;

    assign crc_upd  = crc32c_byte(r_crc, din);
    assign len_full = {din, r_len[23:0]};
    assign len_over = len_full > r_max_len;
    assign len_zero = len_full == 32'd0;
    // on a zero-length record the CRC covers just the length bytes, so
    // crc_upd is the right value in both header and payload cases
    assign crc_ok   = crc_mask(crc_upd) == r_stored;
    assign hdr_last = r_hdr_cnt == 3'(HDR_BYTES - 1);
    assign pay_last = r_left == 32'd1;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_stored  = r_stored;
        n_len     = r_len;
        n_left    = r_left;
        n_crc     = r_crc;
        unique case (r_phase)
            PH_HEADER: begin
                if (eol) begin
                    n_phase = PH_ENDED;
                end else begin
                    if (!r_hdr_cnt[2]) begin
                        // checksum bytes, little endian
                        case (r_hdr_cnt[1:0])
                            2'd0:    n_stored[7:0]   = din;
                            2'd1:    n_stored[15:8]  = din;
                            2'd2:    n_stored[23:16] = din;
                            default: n_stored[31:24] = din;
                        endcase
                    end else begin
                        case (r_hdr_cnt[1:0])
                            2'd0:    n_len[7:0]   = din;
                            2'd1:    n_len[15:8]  = din;
                            2'd2:    n_len[23:16] = din;
                            default: n_len[31:24] = din;
                        endcase
                        n_crc = crc_upd;
                    end
                    if (!hdr_last) begin
                        n_hdr_cnt = r_hdr_cnt + 3'd1;
                    end else begin
                        n_hdr_cnt = 3'd0;
                        if (len_over || len_zero) begin
                            // reported now; next byte starts a new header
                            n_crc = CRC_INIT;
                        end else begin
                            n_left  = len_full;
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                if (eol) begin
                    n_phase = PH_ENDED;
                end else begin
                    n_crc  = crc_upd;
                    n_left = r_left - 32'd1;
                    if (pay_last) begin
                        n_phase   = PH_HEADER;
                        n_hdr_cnt = 3'd0;
                        n_crc     = CRC_INIT;
                    end
                end
            end
            default: begin
                // ended: everything ignored until reset
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Result for the word being taken
    // ---------------------------------------------------------------
    logic       res_valid;
    logic [7:0] res_byte;
    logic       res_bvalid;
    logic [2:0] res_status;
    logic       res_last;

    always_comb begin
        res_valid  = 1'b0;
        res_byte   = 8'd0;
        res_bvalid = 1'b0;
        res_status = ST_BUSY;
        res_last   = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                if (eol) begin
                    res_valid  = 1'b1;
                    res_status = (r_hdr_cnt == 3'd0) ? ST_CLEAN_END : ST_TRUNCATED;
                    res_last   = 1'b1;
                end else if (hdr_last && len_over) begin
                    res_valid  = 1'b1;
                    res_status = ST_TOO_LONG;
                    res_last   = 1'b1;
                end else if (hdr_last && len_zero) begin
                    res_valid  = 1'b1;
                    res_status = crc_ok ? ST_GOOD : ST_BAD_CRC;
                    res_last   = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                res_valid = 1'b1;
                if (eol) begin
                    res_status = ST_TRUNCATED;
                    res_last   = 1'b1;
                end else begin
                    res_byte   = din;
                    res_bvalid = 1'b1;
                    if (pay_last) begin
                        res_status = crc_ok ? ST_GOOD : ST_BAD_CRC;
                        res_last   = 1'b1;
                    end
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= 3'd0;
            r_crc     <= CRC_INIT;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_crc     <= n_crc;
        end
    end

    // header fields and byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored <= 32'd0;
            r_len    <= 32'd0;
            r_left   <= 32'd0;
        end else if (in_acc) begin
            r_stored <= n_stored;
            r_len    <= n_len;
            r_left   <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_out_byte   <= res_byte;
            r_out_bvalid <= res_bvalid;
            r_out_status <= res_status;
            r_out_last   <= res_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = {r_out_status, r_out_bvalid};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> rtl/core/lrd_checker.sv
// Port-level checks for the log record deframer, bound to the top level.
// Depends on lrd_pkg and log_record_deframer.
`timescale 1ns / 1ps
`default_nettype none

module lrd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [3:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);
    import lrd_pkg::*;

    logic [2:0] status;
    logic       bvalid;
    logic       out_acc;
    logic       log_end;

    assign status  = m_axis_tuser[3:1];
    assign bvalid  = m_axis_tuser[0];
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign log_end = status == ST_CLEAN_END || status == ST_TRUNCATED;

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // tlast exactly on a final status
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (status != ST_BUSY)))
        else $error("tlast does not match record status");

    // words without a payload byte are final and carry zero data
    a_nodata_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !bvalid |-> m_axis_tlast && m_axis_tdata == 8'd0)
        else $error("non-payload word not final or data not zero");

    // log end words carry no byte
    a_end_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && log_end |-> !bvalid)
        else $error("log end word carries a payload byte");

    // nothing follows the log end word
    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && log_end |=> !m_axis_tvalid)
        else $error("output after end of log");

endmodule

bind log_record_deframer lrd_checker u_lrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> dv/log_record_deframer_tb.sv
// Self-checking testbench for log_record_deframer: framed log streams in, records checked out.
// Depends on lrd_pkg and log_record_deframer; builds its own expectations word by word.
`timescale 1ns / 1ps

module log_record_deframer_tb;

    import lrd_pkg::*;

    localparam int          CLK_HALF      = 4;     // 8 ns period
    localparam int          PHASE_WORDS   = 135;   // random words per register setting
    localparam int          LONG_HOLD     = 80;    // one long sink back-pressure stretch
    localparam int          SETTLE_CYCLES = 3;     // block answers in the cycle after a word
    localparam int          QUIET_LIMIT   = 2000;  // cycles without any handshake
    localparam int          SUM_BYTES     = HDR_BYTES / 2;
    localparam logic [2:0]  MAX_LEN_ADDR  = {REG_MAX_LEN, 2'b00};
    localparam logic [2:0]  UNUSED_ADDR   = {~REG_MAX_LEN, 2'b00};

    // one input word: tdata carries data, tuser carries the end marker
    typedef struct packed {
        logic       eol;
        logic [7:0] data;
    } t_log_word;

    // one result word, with the fields the block reports
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic [2:0] status;
        logic       last;
    } t_rec_out;

    // parser state of the deframer
    typedef struct packed {
        t_phase      phase;
        logic [2:0]  count;
        logic [31:0] sum;
        logic [31:0] len;
        logic [31:0] left;
        logic [31:0] crc;
    } t_parser;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic        s_axis_tuser  = 1'b0; // [0] end_of_log

    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [7:0]  m_axis_tdata;         // [7:0] payload_byte
    wire  [3:0]  m_axis_tuser;         // [0] byte_valid, [3:1] record_status
    wire         m_axis_tlast;         // record_last

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    wire  [31:0] prdata;
    wire         pready;

    log_record_deframer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Shared state
    // ---------------------------------------------------------------------
    t_log_word   log_feed[$];          // words waiting for the driver
    t_rec_out    due_results[$];       // predicted result words, oldest first
    t_parser     model_parser;         // tracks the block, advanced on accepted words
    t_parser     gen_parser;           // tracks the stream as it is generated
    logic [31:0] max_len       = DEFAULT_MAX_LEN;  // mirror of max_record_length
    int          words_fed     = 0;
    int          words_taken   = 0;
    int          err_count     = 0;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    int          src_gap       = 0;
    int          sink_wait     = 0;
    int          stall_epoch   = 0;    // bumped to request one long sink hold
    int          stall_seen    = 0;
    int          quiet_cycles  = 0;

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------
    // bit-serial reflected CRC-32C, no final inversion
    function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
            r = (r >> 1) ^ ({32{r[0] ^ b[i]}} & CRC_POLY);
        return r;
    endfunction

    // value stored in a header: inverted CRC, rotated right 15, plus delta
    function automatic logic [31:0] header_sum(input logic [31:0] acc);
        logic [31:0] c;
        c = ~acc;
        return ((c >> 15) | (c << 17)) + MASK_DELTA;
    endfunction

    function automatic t_parser fresh_parser();
        t_parser st;
        st       = '0;
        st.phase = PH_HEADER;
        st.crc   = CRC_INIT;
        return st;
    endfunction

    // advance a parser by one input word; hit says whether a result word comes out
    task automatic parse_word(inout t_parser st, input logic [31:0] limit,
                              input t_log_word w, output logic hit, output t_rec_out res);
        logic restart;
        hit     = 1'b0;
        res     = '0;
        restart = 1'b0;
        // ended (or the unused phase code): everything is dropped
        if (st.phase == PH_HEADER || st.phase == PH_PAYLOAD) begin
            if (w.eol) begin
                hit        = 1'b1;
                res.last   = 1'b1;
                res.status = (st.phase == PH_HEADER && st.count == 3'd0) ? ST_CLEAN_END
                                                                         : ST_TRUNCATED;
                st.phase   = PH_ENDED;
            end else if (st.phase == PH_HEADER) begin
                if (st.count < SUM_BYTES) begin
                    st.sum[8*st.count +: 8] = w.data;
                end else begin
                    st.len[8*(st.count - SUM_BYTES) +: 8] = w.data;
                    st.crc = crc_step(st.crc, w.data);
                end
                if (st.count != HDR_BYTES - 1) begin
                    st.count = st.count + 3'd1;
                end else if (st.len > limit) begin
                    // reported now, next word starts a fresh header
                    hit        = 1'b1;
                    res.status = ST_TOO_LONG;
                    res.last   = 1'b1;
                    restart    = 1'b1;
                end else if (st.len == 0) begin
                    hit        = 1'b1;
                    res.status = (header_sum(st.crc) == st.sum) ? ST_GOOD : ST_BAD_CRC;
                    res.last   = 1'b1;
                    restart    = 1'b1;
                end else begin
                    st.count = 3'd0;
                    st.left  = st.len;
                    st.phase = PH_PAYLOAD;
                end
            end else begin
                st.crc    = crc_step(st.crc, w.data);
                st.left   = st.left - 32'd1;
                hit       = 1'b1;
                res.data  = w.data;
                res.valid = 1'b1;
                if (st.left == 0) begin
                    res.status = (header_sum(st.crc) == st.sum) ? ST_GOOD : ST_BAD_CRC;
                    res.last   = 1'b1;
                    restart    = 1'b1;
                end else begin
                    res.status = ST_BUSY;
                end
            end
        end
        if (restart) begin
            st.phase = PH_HEADER;
            st.count = 3'd0;
            st.crc   = CRC_INIT;
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: offers words from log_feed, holds tvalid until taken
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : feed_driver
        t_log_word w;
        logic      hit;
        t_rec_out  res;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap       <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_word(model_parser, max_len, {s_axis_tuser, s_axis_tdata}, hit, res);
                if (hit)
                    due_results.push_back(res);
                words_taken <= words_taken + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 1) begin
                    src_gap       <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (src_gap == 0 && src_idle_pct != 0
                             && $urandom_range(99, 0) < src_idle_pct) begin
                    src_gap       <= $urandom_range(11, 1);
                    s_axis_tvalid <= 1'b0;
                end else if (log_feed.size() != 0) begin
                    w             = log_feed.pop_front();
                    src_gap       <= 0;
                    s_axis_tdata  <= w.data;
                    s_axis_tuser  <= w.eol;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    src_gap       <= 0;
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: checks each taken result word, drives sink back-pressure
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_rec_out want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result word: tdata %0h tuser %0h tlast %0b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    err_count++;
                end else begin
                    want = due_results.pop_front();
                    if (m_axis_tdata !== want.data) begin
                        $error("payload_byte: expected %0h, got %0h", want.data, m_axis_tdata);
                        err_count++;
                    end
                    if (m_axis_tuser[0] !== want.valid) begin
                        $error("byte_valid: expected %0b, got %0b", want.valid, m_axis_tuser[0]);
                        err_count++;
                    end
                    if (m_axis_tuser[3:1] !== want.status) begin
                        $error("record_status: expected %0d, got %0d",
                               want.status, m_axis_tuser[3:1]);
                        err_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("record_last: expected %0b, got %0b", want.last, m_axis_tlast);
                        err_count++;
                    end
                end
            end
            // long hold fills the output register and stalls the input side
            if (stall_epoch != stall_seen) begin
                stall_seen    <= stall_epoch;
                sink_wait     <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else if (sink_wait > 1) begin
                sink_wait     <= sink_wait - 1;
                m_axis_tready <= 1'b0;
            end else if (sink_wait == 0 && sink_idle_pct != 0
                         && $urandom_range(99, 0) < sink_idle_pct) begin
                sink_wait     <= $urandom_range(11, 1);
                m_axis_tready <= 1'b0;
            end else begin
                sink_wait     <= 0;
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: no handshake on either side for too long ends the run
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("log_record_deframer_tb: done, errors");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic push_word(input logic [7:0] data, input logic eol);
        logic     hit;
        t_rec_out res;
        log_feed.push_back({eol, data});
        parse_word(gen_parser, max_len, {eol, data}, hit, res);
        words_fed++;
    endtask

    // one record; payload only goes out when the length is within the limit
    task automatic send_record(input logic [31:0] len, input logic spoil,
                               input logic extreme_fill);
        logic [31:0] acc;
        logic [31:0] sum;
        logic [7:0]  b;
        logic [7:0]  body[$];
        acc = CRC_INIT;
        for (int i = 0; i < 4; i++)
            acc = crc_step(acc, len[8*i +: 8]);
        if (len <= max_len) begin
            for (int i = 0; i < len; i++) begin
                b = extreme_fill ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
                body.push_back(b);
                acc = crc_step(acc, b);
            end
        end
        sum = header_sum(acc);
        if (spoil)
            sum ^= 32'd1 << $urandom_range(31, 0);
        for (int i = 0; i < SUM_BYTES; i++)
            push_word(sum[8*i +: 8], 1'b0);
        for (int i = 0; i < 4; i++)
            push_word(len[8*i +: 8], 1'b0);
        foreach (body[i])
            push_word(body[i], 1'b0);
    endtask

    // pad with noise until the stream sits on a record boundary again
    task automatic finish_record();
        while (gen_parser.phase != PH_HEADER || gen_parser.count != 3'd0)
            push_word(8'($urandom), 1'b0);
    endtask

    // mostly short records; limit and limit+1 probe the length compare
    function automatic logic [31:0] pick_length(input logic [31:0] limit);
        logic [31:0] n;
        case ($urandom_range(7, 0))
            0:       n = 32'd0;
            1:       n = limit + 1;
            2:       n = limit;
            3:       n = $urandom;
            default: n = $urandom_range(24, 1);
        endcase
        if (n <= limit && n > 64)
            n = $urandom_range(24, 1);
        return n;
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(2, 0))
            0:       return 0;
            1:       return 5;
            default: return 20;
        endcase
    endfunction

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_limit_reg();
        logic [31:0] rd;
        apb_access(1'b0, MAX_LEN_ADDR, '0, rd);
        if (rd !== max_len) begin
            $error("max_record_length readback: expected %0h, got %0h", max_len, rd);
            err_count++;
        end
    endtask

    // writes to the spare address must leave max_record_length alone
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] ignored;
        apb_access(1'b1, addr, value, ignored);
        if (addr == MAX_LEN_ADDR)
            max_len = value;
        check_limit_reg();
    endtask

    // all words taken and all results seen, then a settle wait for header-only words
    task automatic wait_drained();
        do @(posedge i_clk); while (words_taken != words_fed || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [31:0] limit, input int src_pct, input int sink_pct,
                             input logic long_hold);
        int start_count;
        write_reg(MAX_LEN_ADDR, limit);
        src_idle_pct  <= src_pct;
        sink_idle_pct <= sink_pct;
        start_count   = words_fed;
        while (words_fed - start_count < PHASE_WORDS) begin
            // raw noise headers only under small limits so lengths stay short
            if (limit <= 64 && $urandom_range(15, 0) == 0) begin
                repeat (HDR_BYTES) push_word(8'($urandom), 1'b0);
                finish_record();
            end else begin
                send_record(pick_length(limit), $urandom_range(5, 0) == 0, 1'b0);
            end
        end
        finish_record();
        if (long_hold)
            stall_epoch <= stall_epoch + 1;
        // sender pauses here until every result has come back
        wait_drained();
    endtask

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] limits [8];
        model_parser = fresh_parser();
        gen_parser   = fresh_parser();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_limit_reg();

        // directed: zero length checked at once, bad checksum on the last
        // payload byte (00/ff payload), spare register, all-ones length too long
        send_record(32'd0, 1'b0, 1'b1);
        send_record(32'd2, 1'b1, 1'b1);
        wait_drained();
        write_reg(UNUSED_ADDR, 32'd0);
        write_reg(MAX_LEN_ADDR, 32'd1);
        send_record('1, 1'b0, 1'b1);
        wait_drained();

        // random: a sweep of limits, both extremes included
        limits[0] = 32'd0;
        limits[1] = 32'd1;
        limits[2] = 32'd16;
        limits[3] = '1;
        limits[4] = DEFAULT_MAX_LEN;
        limits[5] = 32'd5;
        limits[6] = $urandom_range(60, 2);
        limits[7] = 32'd40;
        for (int p = 0; p < 8; p++) begin
            // long hold once; last phase runs without idling
            run_phase(limits[p], (p == 7) ? 0 : pick_pct(), (p == 7) ? 0 : pick_pct(), p == 2);
        end

        // end of log: clean, inside a header, or inside a payload
        case ($urandom_range(2, 0))
            0: ;
            1: repeat ($urandom_range(HDR_BYTES - 1, 1)) push_word(8'($urandom), 1'b0);
            default: begin
                for (int i = 0; i < SUM_BYTES; i++)
                    push_word(8'($urandom), 1'b0);
                push_word(8'd9, 1'b0);           // 9-byte record, cut after 3 bytes
                repeat (3) push_word(8'd0, 1'b0);
                repeat (3) push_word(8'($urandom), 1'b0);
            end
        endcase
        push_word(8'($urandom), 1'b1);
        // everything after the end marker is dropped, markers too
        repeat (6) push_word(8'($urandom), 1'($urandom));
        push_word(8'($urandom), 1'b1);
        wait_drained();

        if (err_count == 0 && due_results.size() == 0)
            $display("log_record_deframer_tb: done, clean");
        else
            $display("log_record_deframer_tb: done, errors");
        $finish;
    end

endmodule

>>> files.f
rtl/core/lrd_pkg.sv
rtl/core/log_record_deframer.sv
rtl/core/lrd_checker.sv
dv/log_record_deframer_tb.sv
